>>> hdl/ifp_pkg.sv
// ifp_pkg: constants and types shared by the IMU frame parser.
// No dependencies; compiled first.
package ifp_pkg;

  // Frame layout
  localparam int FrameLen = 11;           // bytes in one frame
  localparam int WinCells = FrameLen - 1; // held bytes; the eleventh is the arriving item
  localparam int FillW    = 4;            // fill count 0..WinCells

  // Byte codes
  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeRate   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  // One emitted record
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
  } record_t;

endpackage

>>> hdl/ifp_byte_if.sv
// ifp_byte_if: valid/ready channel carrying one received serial byte.
// No dependencies.
interface ifp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hdl/ifp_rec_if.sv
// ifp_rec_if: valid/ready channel carrying one parsed IMU record.
// No dependencies.
interface ifp_rec_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic signed [15:0] roll_raw;
  logic signed [15:0] pitch_raw;
  logic signed [15:0] yaw_raw;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output rate_x, output rate_y, output rate_z,
                  output roll_raw, output pitch_raw, output yaw_raw,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input rate_x, input rate_y, input rate_z,
                  input roll_raw, input pitch_raw, input yaw_raw,
                  output ready);
endinterface

>>> hdl/ifp_cell.sv
// ifp_cell: one byte cell of the frame window shift line.
// Holds a byte, passes it toward the older end and adds it into the checksum chain.
module ifp_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] sum_in,
  output logic [7:0] byte_q,
  output logic [7:0] sum_out
);

  logic [7:0] byte_r;

  // Byte register, loads from the newer neighbor on each accepted item
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // Running checksum, modulo 256
  assign sum_out = sum_in + byte_r;
  assign byte_q  = byte_r;

endmodule

>>> hdl/imu_frame_parser.sv
// imu_frame_parser: top level of the 11-byte serial IMU frame parser.
// Depends on ifp_pkg, ifp_byte_if, ifp_rec_if and ifp_cell.
//
// The parser takes one received byte per clock cycle while in_chan.ready is high. Ten byte
// cells form a shift line that holds the newest ten bytes; when ten are held, the arriving
// byte completes a candidate frame, which is checked in that same cycle (header 0x55, and
// the ten-byte sum carried down the cell chain against the arriving checksum byte). A bad
// candidate just keeps sliding, which resynchronizes one byte at a time; a good frame empties
// the window. Acceleration (0x51) and rate (0x52) frames update the held values, and an angle
// frame (0x53) emits one record into the output register, or into the skid entry while that
// register is occupied. Records pass through an output register with a one-entry skid, so
// in_chan.ready drops only while two records wait unread.
module imu_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  ifp_byte_if.sink   in_chan,
  ifp_rec_if.source  out_chan
);

  import ifp_pkg::*;

  logic             in_acc;
  logic [7:0]       cell_q   [WinCells];
  logic [7:0]       cell_d   [WinCells];
  logic [7:0]       sum_c    [WinCells+1];
  logic [FillW-1:0] fill_r, fill_nxt;
  logic             full;
  logic             frame_ok;
  logic [7:0]       frame_type;
  logic [15:0]      word [3];
  logic [15:0]      held_accel_r [3];
  logic [15:0]      held_rate_r  [3];
  logic             emit;
  record_t          rec_new;
  record_t          out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             pop;

  assign in_acc = in_chan.valid && in_chan.ready;

  // Window shift line: cell 0 holds the oldest byte, the last cell takes the new item
  assign sum_c[0] = 8'd0;
  for (genvar i = 0; i < WinCells; i++) begin : g_cell
    if (i == WinCells - 1) begin : g_tail
      assign cell_d[i] = in_chan.rx_byte;
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end
    ifp_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (cell_d[i]),
      .sum_in   (sum_c[i]),
      .byte_q   (cell_q[i]),
      .sum_out  (sum_c[i+1])
    );
  end

  // Frame check on the held ten bytes plus the arriving checksum byte
  assign full       = (fill_r == FillW'(WinCells));
  assign frame_ok   = full && (cell_q[0] == HeaderByte) && (sum_c[WinCells] == in_chan.rx_byte);
  assign frame_type = cell_q[1];
  for (genvar k = 0; k < 3; k++) begin : g_word
    assign word[k] = {cell_q[3+2*k], cell_q[2+2*k]};
  end

  // Fill count
  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) begin
      if (!full) begin
        fill_nxt = fill_r + FillW'(1);
      end else if (frame_ok) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Held acceleration and rate, updated by valid frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        held_accel_r[k] <= '0;
        held_rate_r[k]  <= '0;
      end
    end else if (in_acc && frame_ok) begin
      unique case (frame_type)
        TypeAccel: begin
          for (int k = 0; k < 3; k++) begin
            held_accel_r[k] <= word[k];
            held_rate_r[k]  <= '0;
          end
        end
        TypeRate: begin
          for (int k = 0; k < 3; k++) begin
            held_rate_r[k] <= word[k];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Record assembled from held values and the angle words of this frame
  assign emit = in_acc && frame_ok && (frame_type == TypeAngle);
  always_comb begin
    rec_new.accel_x   = held_accel_r[0];
    rec_new.accel_y   = held_accel_r[1];
    rec_new.accel_z   = held_accel_r[2];
    rec_new.rate_x    = held_rate_r[0];
    rec_new.rate_y    = held_rate_r[1];
    rec_new.rate_z    = held_rate_r[2];
    rec_new.roll_raw  = word[0];
    rec_new.pitch_raw = word[1];
    rec_new.yaw_raw   = word[2];
  end

  // Output register with one-entry skid
  assign pop           = out_valid_r && out_chan.ready;
  assign in_chan.ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= emit;
          if (emit) begin
            skid_r <= rec_new;
          end
        end else if (emit) begin
          out_r <= rec_new;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (emit) begin
        if (!out_valid_r) begin
          out_r       <= rec_new;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= rec_new;
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.accel_x   = out_r.accel_x;
  assign out_chan.accel_y   = out_r.accel_y;
  assign out_chan.accel_z   = out_r.accel_z;
  assign out_chan.rate_x    = out_r.rate_x;
  assign out_chan.rate_y    = out_r.rate_y;
  assign out_chan.rate_z    = out_r.rate_z;
  assign out_chan.roll_raw  = out_r.roll_raw;
  assign out_chan.pitch_raw = out_r.pitch_raw;
  assign out_chan.yaw_raw   = out_r.yaw_raw;

endmodule

>>> hdl/ifp_checker.sv
// ifp_checker: port-level assertions for imu_frame_parser, attached by bind.
// Depends on imu_frame_parser and its channel interfaces.
module ifp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [143:0] out_data
);

  // A stalled record holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("record changed while stalled");

  // A record appears only right after an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("record without a completing item");

  // Input stalls only while the output register is occupied
  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind imu_frame_parser ifp_checker u_ifp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  ({out_chan.accel_x, out_chan.accel_y, out_chan.accel_z,
               out_chan.rate_x, out_chan.rate_y, out_chan.rate_z,
               out_chan.roll_raw, out_chan.pitch_raw, out_chan.yaw_raw})
);

>>> verif/ifp_record_checker.sv
`timescale 1ns / 1ps
// ifp_record_checker: watches the byte and record channels of imu_frame_parser, predicts
// each record from the accepted bytes and compares it field by field.
// Depends on ifp_pkg, ifp_byte_if and ifp_rec_if.
module ifp_record_checker (
  input  logic clk,
  input  logic rst_n,
  ifp_byte_if  byte_mon,
  ifp_rec_if   rec_mon,
  output int   mismatch_count,
  output int   pending_records
);
  import ifp_pkg::*;

  localparam string FieldName [9] = '{"yaw_raw", "pitch_raw", "roll_raw", "rate_z", "rate_y",
                                      "rate_x", "accel_z", "accel_y", "accel_x"};

  // Parser state as the block should hold it
  logic [7:0]         byte_window [$];
  logic signed [15:0] held_accel [3];
  logic signed [15:0] held_rate [3];
  record_t            record_queue [$];

  // Little-endian payload word k of the frame in the window
  function automatic logic signed [15:0] frame_word(int k);
    return {byte_window[3 + 2 * k], byte_window[2 + 2 * k]};
  endfunction

  // Advance the parser by one byte; queue a record for a good angle frame
  function automatic void parse_byte(logic [7:0] rx);
    logic [7:0] sum;
    record_t    rec;
    byte_window.push_back(rx);
    if (byte_window.size() < FrameLen) return;
    sum = '0;
    for (int i = 0; i < FrameLen - 1; i++) sum += byte_window[i];
    // bad header or checksum: slide by one byte
    if (byte_window[0] != HeaderByte || sum != byte_window[FrameLen - 1]) begin
      void'(byte_window.pop_front());
      return;
    end
    case (byte_window[1])
      TypeAccel: begin
        for (int k = 0; k < 3; k++) begin
          held_accel[k] = frame_word(k);
          held_rate[k]  = '0;
        end
      end
      TypeRate: begin
        for (int k = 0; k < 3; k++) held_rate[k] = frame_word(k);
      end
      TypeAngle: begin
        rec.accel_x   = held_accel[0];
        rec.accel_y   = held_accel[1];
        rec.accel_z   = held_accel[2];
        rec.rate_x    = held_rate[0];
        rec.rate_y    = held_rate[1];
        rec.rate_z    = held_rate[2];
        rec.roll_raw  = frame_word(0);
        rec.pitch_raw = frame_word(1);
        rec.yaw_raw   = frame_word(2);
        record_queue.push_back(rec);
      end
      default: ;
    endcase
    byte_window.delete();
  endfunction

  // Compare one accepted record with the oldest prediction
  function automatic void check_record();
    record_t           seen;
    logic [8:0][15:0]  want_w;
    logic [8:0][15:0]  seen_w;
    seen.accel_x   = rec_mon.accel_x;
    seen.accel_y   = rec_mon.accel_y;
    seen.accel_z   = rec_mon.accel_z;
    seen.rate_x    = rec_mon.rate_x;
    seen.rate_y    = rec_mon.rate_y;
    seen.rate_z    = rec_mon.rate_z;
    seen.roll_raw  = rec_mon.roll_raw;
    seen.pitch_raw = rec_mon.pitch_raw;
    seen.yaw_raw   = rec_mon.yaw_raw;
    if (record_queue.size() == 0) begin
      $display("%0t: unexpected record, expected none, got %h", $time, seen);
      mismatch_count++;
      return;
    end
    want_w = record_queue.pop_front();
    seen_w = seen;
    for (int k = 8; k >= 0; k--) begin
      if (seen_w[k] !== want_w[k]) begin
        $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, FieldName[k],
                 $signed(want_w[k]), want_w[k], $signed(seen_w[k]), seen_w[k]);
        mismatch_count++;
      end
    end
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_window.delete();
      record_queue.delete();
      for (int k = 0; k < 3; k++) begin
        held_accel[k] = '0;
        held_rate[k]  = '0;
      end
    end else begin
      if (byte_mon.valid && byte_mon.ready) parse_byte(byte_mon.rx_byte);
      if (rec_mon.valid && rec_mon.ready) check_record();
    end
    pending_records = record_queue.size();
  end

  initial begin
    mismatch_count  = 0;
    pending_records = 0;
  end

endmodule

>>> verif/imu_frame_parser_tb.sv
`timescale 1ns / 1ps
// imu_frame_parser_tb: drives byte streams of good, broken and foreign frames into
// imu_frame_parser with random gaps and stalls. Depends on ifp_pkg, the two channel
// interfaces, the parser RTL and ifp_record_checker.
module imu_frame_parser_tb;
  import ifp_pkg::*;

  localparam int IdlePct     = 17;
  localparam int RandItems   = 800;
  localparam int HoldCycles  = 120;
  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 20;
  localparam logic [7:0] TypeOther = 8'h54;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   no_idle = 1'b0;
  bit   hold_request = 1'b0;
  int   bytes_sent = 0;
  int   quiet_cycles = 0;
  int   mismatch_count;
  int   pending_records;

  ifp_byte_if byte_ch ();
  ifp_rec_if  rec_ch ();

  imu_frame_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_ch),
    .out_chan (rec_ch)
  );

  ifp_record_checker rec_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_mon        (byte_ch),
    .rec_mon         (rec_ch),
    .mismatch_count  (mismatch_count),
    .pending_records (pending_records)
  );

  always #6 clk = ~clk;

  // Watchdog: ends the run when no item moves for too long
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, QuietLimit);
      $display("** imu_frame_parser: FAILED **");
      $finish;
    end
  end

  // Record receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    rec_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Offer one byte, with idle cycles ahead of it at the idle rate, and wait until it is taken
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= rx;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // One frame; optionally spoil the header or the checksum
  task automatic send_frame(input logic [7:0] kind, input logic [15:0] w0, w1, w2,
                            input bit bad_head = 1'b0, input bit bad_sum = 1'b0);
    logic [7:0] fr [11];
    logic [7:0] sum;
    fr[0] = bad_head ? (HeaderByte ^ 8'($urandom_range(255, 1))) : HeaderByte;
    fr[1] = kind;
    {fr[3], fr[2]} = w0;
    {fr[5], fr[4]} = w1;
    {fr[7], fr[6]} = w2;
    fr[8] = 8'($urandom);
    fr[9] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < 10; i++) sum += fr[i];
    fr[10] = bad_sum ? (sum ^ (8'h01 << $urandom_range(7))) : sum;
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  // Payload word, weighted toward the int16 extremes
  function automatic logic [15:0] pick_word();
    logic [15:0] edges [5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
    if ($urandom_range(99) < 20) return edges[$urandom_range(4)];
    return 16'($urandom);
  endfunction

  // Stimulus
  initial begin
    int pick;
    int frame_no;
    logic [7:0] odd_kind;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: leading junk forces a resync, then each frame type at the extremes and a bad checksum
    send_byte(8'hA5);
    send_frame(TypeAngle, 16'h0123, 16'hFEDC, 16'h0000);
    send_frame(TypeAccel, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_frame(TypeRate,  16'h0001, 16'h8000, 16'h7FFF);
    send_frame(TypeAngle, 16'h7FFF, 16'h0000, 16'h8000);
    send_frame(TypeOther, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(TypeAngle, 16'h1111, 16'h2222, 16'h3333, 1'b0, 1'b1);
    send_frame(TypeAccel, 16'h0000, 16'hFFFF, 16'h5A5A);
    send_frame(TypeAngle, 16'hFFFF, 16'h7FFF, 16'h0001);

    // Random: mostly well-formed frames, some broken ones and noise
    frame_no = 0;
    while (bytes_sent < RandItems && frame_no < 2000) begin
      no_idle = (frame_no >= 15 && frame_no < 40);
      if (frame_no == 50) begin
        // long receiver hold-off while angle frames keep coming
        hold_request = 1'b1;
        repeat (5) send_frame(TypeAngle, pick_word(), pick_word(), pick_word());
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_frame(TypeAccel, pick_word(), pick_word(), pick_word());
      end else if (pick < 40) begin
        send_frame(TypeRate, pick_word(), pick_word(), pick_word());
      end else if (pick < 80) begin
        send_frame(TypeAngle, pick_word(), pick_word(), pick_word());
      end else if (pick < 86) begin
        if ($urandom_range(1)) begin
          odd_kind = TypeOther;
        end else begin
          do odd_kind = 8'($urandom); while (odd_kind >= TypeAccel && odd_kind <= TypeAngle);
        end
        send_frame(odd_kind, pick_word(), pick_word(), pick_word());
      end else if (pick < 93) begin
        pick = $urandom_range(1);
        send_frame(TypeAngle, pick_word(), pick_word(), pick_word(), pick == 0, pick == 1);
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
      frame_no++;
    end
    no_idle = 1'b0;
    byte_ch.valid <= 1'b0;

    // Drain, then allow time for any stray record
    while (pending_records != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** imu_frame_parser: PASSED **");
    end else begin
      $display("** imu_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
